FILE: rtl/file_transfer_frame_receiver_unit_macros.svh
// Assertion macros shared by the checker of the file frame receiver.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FILE_TRANSFER_FRAME_RECEIVER_UNIT_MACROS_SVH
`define FILE_TRANSFER_FRAME_RECEIVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ftfr_pkg.sv
// Package of the file frame receiver: codes, constants, shared types and
// the magic byte table. No dependencies.
package ftfr_pkg;

  localparam int BUFFER_BYTES = 65536;
  localparam int NAME_BYTES   = 12;

  localparam int LIMIT_W   = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [LIMIT_W-1:0] HDR_LIMIT_RST = 20'd500000;
  localparam logic [LIMIT_W-1:0] PAY_LIMIT_RST = 20'd1000000;
  localparam logic [LIMIT_W-1:0] TRL_LIMIT_RST = 20'd100000;

  localparam logic [7:0] CK_DEFAULT = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HDR_LIMIT = 2'd0,
    CFG_PAY_LIMIT = 2'd1,
    CFG_TRL_LIMIT = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_IDLE   = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    KIND_NONE      = 4'd0,
    KIND_MAGIC     = 4'd1,
    KIND_NAME      = 4'd2,
    KIND_SIZE      = 4'd3,
    KIND_PAYLOAD   = 4'd4,
    KIND_CHECKSUM  = 4'd5,
    KIND_DONE      = 4'd6,
    KIND_TOO_LARGE = 4'd7,
    KIND_CANCELLED = 4'd8,
    KIND_TIMEOUT   = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_NAME    = 3'd1,
    PH_SIZE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4,
    PH_TRAILER = 3'd5
  } phase_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] hdr;
    logic [LIMIT_W-1:0] pay;
    logic [LIMIT_W-1:0] trl;
  } limits_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic [15:0] offset;
    logic [31:0] fsize;
    logic        ok;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = 8'h4F;
      2'd1:    b = 8'h53;
      2'd2:    b = 8'h33;
      default: b = 8'h32;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/ftfr_if.sv
// Valid/ready channel interfaces for the input events and the result events
// of the file frame receiver. No dependencies.
interface ftfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface ftfr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [7:0]  event_value;
  logic [15:0] event_offset;
  logic [31:0] frame_size;
  logic        checksum_ok;

  modport source (
    output valid, output event_kind, output event_value, output event_offset,
    output frame_size, output checksum_ok, input ready
  );
  modport sink (
    input valid, input event_kind, input event_value, input event_offset,
    input frame_size, input checksum_ok, output ready
  );
endinterface

FILE: rtl/ftfr_cfg.sv
// Idle limit registers of the file frame receiver, written through a plain
// write port. Depends on ftfr_pkg.
module ftfr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ftfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ftfr_pkg::LIMIT_W-1:0]   cfg_wdata,
  output ftfr_pkg::limits_t             limits
);
  import ftfr_pkg::*;

  limits_t lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.hdr <= HDR_LIMIT_RST;
      lim_r.pay <= PAY_LIMIT_RST;
      lim_r.trl <= TRL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HDR_LIMIT: lim_r.hdr <= cfg_wdata;
        CFG_PAY_LIMIT: lim_r.pay <= cfg_wdata;
        CFG_TRL_LIMIT: lim_r.trl <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign limits = lim_r;

endmodule

FILE: rtl/ftfr_core.sv
// Frame state machine of the file frame receiver: one event is stepped per
// enabled cycle and its result is produced combinationally. Depends on ftfr_pkg.
module ftfr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [1:0]        action,
  input  logic [7:0]        rx_byte,
  input  ftfr_pkg::limits_t limits,
  output ftfr_pkg::result_t res
);
  import ftfr_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [3:0]          fidx_r, fidx_nxt;
  logic [31:0]         size_r, size_nxt;
  logic [16:0]         rcvd_r, rcvd_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic [LIMIT_W-1:0]  idle_r, idle_nxt;
  logic                match_r, match_nxt;

  logic [LIMIT_W-1:0]  lim_sel;
  logic [LIMIT_W:0]    idle_inc;
  logic                expired;
  logic [31:0]         size_new;
  logic [16:0]         rcvd_inc;
  logic [7:0]          ck;
  logic                ended;
  logic                clr;
  logic                to_name;

  always_comb begin
    case (phase_r)
      PH_PAYLOAD: lim_sel = limits.pay;
      PH_TRAILER: lim_sel = limits.trl;
      default:    lim_sel = limits.hdr;
    endcase
    idle_inc = {1'b0, idle_r} + {{LIMIT_W{1'b0}}, 1'b1};
    expired  = idle_inc > {1'b0, lim_sel};
    size_new = size_r | ({24'd0, rx_byte} << {fidx_r[1:0], 3'b000});
    rcvd_inc = rcvd_r + 17'd1;
  end

  always_comb begin
    phase_nxt  = phase_r;
    fidx_nxt   = fidx_r;
    size_nxt   = size_r;
    rcvd_nxt   = rcvd_r;
    sum_nxt    = sum_r;
    idle_nxt   = idle_r;
    match_nxt  = match_r;
    res        = '0;
    res.kind   = KIND_NONE;
    clr        = 1'b0;
    to_name    = 1'b0;
    ck         = CK_DEFAULT;
    ended      = 1'b0;

    if (action != ACT_UNUSED) begin
      case (phase_r)
        PH_HUNT: begin
          if (action == ACT_CANCEL) begin
            res.kind = KIND_CANCELLED;
            clr      = 1'b1;
          end else if (action == ACT_BYTE) begin
            if (rx_byte == magic_byte(fidx_r[1:0])) begin
              if (fidx_r[1:0] == 2'd3) begin
                res.kind = KIND_MAGIC;
                clr      = 1'b1;
                to_name  = 1'b1;
              end else begin
                fidx_nxt = {2'b00, fidx_r[1:0] + 2'd1};
              end
            end else begin
              fidx_nxt = '0;
            end
          end
        end
        PH_NAME, PH_SIZE, PH_PAYLOAD: begin
          if (action == ACT_CANCEL) begin
            res.kind = KIND_CANCELLED;
            clr      = 1'b1;
          end else if (action == ACT_IDLE) begin
            if (expired) begin
              res.kind = KIND_TIMEOUT;
              clr      = 1'b1;
            end else begin
              idle_nxt = idle_inc[LIMIT_W-1:0];
            end
          end else begin
            idle_nxt = '0;
            if (phase_r == PH_NAME) begin
              res.kind   = KIND_NAME;
              res.value  = rx_byte;
              res.offset = {12'd0, fidx_r};
              if (({1'b0, fidx_r} + 5'd1) >= 5'(NAME_BYTES)) begin
                phase_nxt = PH_SIZE;
                fidx_nxt  = '0;
              end else begin
                fidx_nxt = fidx_r + 4'd1;
              end
            end else if (phase_r == PH_SIZE) begin
              size_nxt = size_new;
              if (fidx_r[1:0] == 2'd3) begin
                res.fsize = size_new;
                if (size_new > 32'(BUFFER_BYTES)) begin
                  res.kind = KIND_TOO_LARGE;
                  clr      = 1'b1;
                end else begin
                  res.kind  = KIND_SIZE;
                  fidx_nxt  = '0;
                  phase_nxt = (size_new == 32'd0) ? PH_CHECK : PH_PAYLOAD;
                end
              end else begin
                fidx_nxt = {2'b00, fidx_r[1:0] + 2'd1};
              end
            end else begin
              res.kind   = KIND_PAYLOAD;
              res.value  = rx_byte;
              res.offset = rcvd_r[15:0];
              res.fsize  = size_r;
              sum_nxt    = sum_r + rx_byte;
              rcvd_nxt   = rcvd_inc;
              if ({15'd0, rcvd_inc} >= size_r) begin
                phase_nxt = PH_CHECK;
              end
            end
          end
        end
        PH_CHECK: begin
          if (action == ACT_BYTE) begin
            ended = 1'b1;
            ck    = rx_byte;
          end else if (action == ACT_CANCEL) begin
            ended = 1'b1;
          end else if (expired) begin
            ended = 1'b1;
          end else begin
            idle_nxt = idle_inc[LIMIT_W-1:0];
          end
          if (ended) begin
            match_nxt = (sum_r == ck);
            res.kind  = KIND_CHECKSUM;
            res.value = ck;
            res.fsize = size_r;
            res.ok    = (sum_r == ck);
            phase_nxt = PH_TRAILER;
            fidx_nxt  = '0;
            idle_nxt  = '0;
          end
        end
        PH_TRAILER: begin
          ended = (action != ACT_IDLE) || expired;
          if (ended) begin
            idle_nxt = '0;
            if (fidx_r >= 4'd2) begin
              res.kind  = KIND_DONE;
              res.fsize = size_r;
              res.ok    = match_r;
              clr       = 1'b1;
            end else begin
              fidx_nxt = fidx_r + 4'd1;
            end
          end else begin
            idle_nxt = idle_inc[LIMIT_W-1:0];
          end
        end
        default: begin
          clr = 1'b1;
        end
      endcase
    end

    if (clr) begin
      phase_nxt = to_name ? PH_NAME : PH_HUNT;
      fidx_nxt  = '0;
      size_nxt  = '0;
      rcvd_nxt  = '0;
      sum_nxt   = '0;
      idle_nxt  = '0;
      match_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      fidx_r  <= '0;
      size_r  <= '0;
      rcvd_r  <= '0;
      sum_r   <= '0;
      idle_r  <= '0;
      match_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      fidx_r  <= fidx_nxt;
      size_r  <= size_nxt;
      rcvd_r  <= rcvd_nxt;
      sum_r   <= sum_nxt;
      idle_r  <= idle_nxt;
      match_r <= match_nxt;
    end
  end

endmodule

FILE: rtl/file_transfer_frame_receiver_unit.sv
// Top level of the file frame receiver: input register, frame state machine,
// result register and idle limit registers. Depends on ftfr_pkg, ftfr_if,
// ftfr_cfg and ftfr_core.
//
// Every accepted transaction (a received byte, an idle tick or a cancel)
// yields exactly one result transaction, in order. The block takes one
// transaction per cycle while the result channel is not stalled; a result
// passes through the input register and then the result register, with the
// frame state machine stepping between them. A stalled result holds in the
// result register while the input register still takes one more transaction.
// The idle limits must be written by the user through the cfg port only while
// no transaction is in flight; the block itself does not enforce this.
module file_transfer_frame_receiver_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  ftfr_in_if.sink                        in_ch,
  ftfr_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ftfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ftfr_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import ftfr_pkg::*;

  logic       in_vld_r;
  logic [1:0] in_action_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  result_t    out_res_r;
  result_t    res;
  limits_t    limits;
  logic       advance;

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_action_r <= in_ch.action;
      in_byte_r   <= in_ch.rx_byte;
    end
  end

  ftfr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .limits    (limits)
  );

  ftfr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .action  (in_action_r),
    .rx_byte (in_byte_r),
    .limits  (limits),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.event_kind   = out_res_r.kind;
  assign out_ch.event_value  = out_res_r.value;
  assign out_ch.event_offset = out_res_r.offset;
  assign out_ch.frame_size   = out_res_r.fsize;
  assign out_ch.checksum_ok  = out_res_r.ok;

endmodule

FILE: rtl/ftfr_checker.sv
// Port-level checker of the file frame receiver and its bind to the top level.
// Depends on ftfr_pkg and file_transfer_frame_receiver_unit_macros.svh.
`include "file_transfer_frame_receiver_unit_macros.svh"

module ftfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_kind,
  input logic [7:0]  out_value,
  input logic [15:0] out_offset,
  input logic [31:0] out_size,
  input logic        out_ok
);
  import ftfr_pkg::*;

  `FTFR_ASSERT_NXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable({out_kind, out_value, out_offset, out_size, out_ok}),
    "stalled result transaction changed")

  `FTFR_ASSERT_IMP(a_offset_zero,
    out_valid && out_kind != KIND_NAME && out_kind != KIND_PAYLOAD,
    out_offset == 16'd0, "offset set on a result without a byte")

  `FTFR_ASSERT_IMP(a_ok_kind,
    out_valid && out_ok, out_kind == KIND_CHECKSUM || out_kind == KIND_DONE,
    "checksum flag set outside checksum or done")

  `FTFR_ASSERT_IMP(a_size_kind,
    out_valid && (out_kind < KIND_SIZE || out_kind > KIND_TOO_LARGE),
    out_size == 32'd0, "frame size set outside the frame events")

  `FTFR_ASSERT_IMP(a_too_large, out_valid && out_kind == KIND_TOO_LARGE,
    out_size > 32'(BUFFER_BYTES), "too large reported for a size that fits")

endmodule

bind file_transfer_frame_receiver_unit ftfr_checker u_ftfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.event_kind),
  .out_value  (out_ch.event_value),
  .out_offset (out_ch.event_offset),
  .out_size   (out_ch.frame_size),
  .out_ok     (out_ch.checksum_ok)
);
